[rtl/core/drrt_pkg.sv]
// shared types, constants and the arctangent table for the release trigger
package drrt_pkg;

   localparam int CORDIC_W = 34;
   localparam int ANGLE_W  = 33;
   localparam int DIV_W    = 22;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLIGHT_DIR  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIST    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_TOL   = 3'd4;

   localparam logic [15:0] K_Q31_LO = 16'h76D4;
   localparam logic [14:0] K_Q31_HI = 15'h4DBA;
   localparam logic signed [CORDIC_W-1:0] K_Q30 = 34'sd652032874;

   typedef enum logic {
      MODE_ROTATE,
      MODE_VECTOR
   } cordic_mode_type;

   // arctangent of 2^-i in 1/2^32 turn
   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] a;
      case (idx)
         5'd0:  a = 32'd536870912;
         5'd1:  a = 32'd316933406;
         5'd2:  a = 32'd167458907;
         5'd3:  a = 32'd85004756;
         5'd4:  a = 32'd42667331;
         5'd5:  a = 32'd21354465;
         5'd6:  a = 32'd10679838;
         5'd7:  a = 32'd5340245;
         5'd8:  a = 32'd2670163;
         5'd9:  a = 32'd1335087;
         5'd10: a = 32'd667544;
         5'd11: a = 32'd333772;
         5'd12: a = 32'd166886;
         5'd13: a = 32'd83443;
         5'd14: a = 32'd41722;
         5'd15: a = 32'd20861;
         5'd16: a = 32'd10430;
         5'd17: a = 32'd5215;
         5'd18: a = 32'd2608;
         5'd19: a = 32'd1304;
         5'd20: a = 32'd652;
         5'd21: a = 32'd326;
         5'd22: a = 32'd163;
         5'd23: a = 32'd81;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

endpackage

[rtl/core/dead_reckoning_release_trigger.sv]
// dead-reckoning release trigger: sequencer, dead reckoning step and release decision
// dead-reckoned tick: rotation pass, multiply, divide and accumulate for x then y, vectoring
// pass, distance steps, decision; a new fix starts at vectoring, one on the release point at
// the decision, an unarmed tick at the result; both passes share one cordic engine; one item
// at a time, the next taken in the cycle after the result is registered; a stalled result beat
// adds its wait; reset: synchronous; disarms, clears position state, loads register defaults
module dead_reckoning_release_trigger #(
   parameter int TICK_RATE    = 60,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // arm, fix_x, fix_y, ground_speed, heading
   input  logic [87:0]                        req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // release_res, armed_now, track_x, track_y, distance
   output logic [79:0]                        rsp_tdata,
   input  logic                               csr_we,
   input  logic [drrt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [23:0]                        csr_wdata
);
   import drrt_pkg::*;

   // ceil(2^32 / TICK_RATE), exact floor division for numerators below 2^22
   localparam logic [32:0] RECIP =
      33'(((64'd1 << 32) + 64'(TICK_RATE) - 64'd1) / 64'(TICK_RATE));

   typedef enum logic [3:0] {
      ST_IDLE, ST_ROT_RUN, ST_MUL, ST_DIV_PREP, ST_DIV_RUN, ST_ACCUM,
      ST_VEC_START, ST_VEC_RUN, ST_DIST_LO, ST_DIST_HI, ST_DIST_FIN,
      ST_DECIDE, ST_DONE
   } state_type;

   state_type state_ff;

   // configuration
   logic signed [23:0] release_x_ff, release_y_ff;
   logic [15:0]        flight_dir_ff, angle_tol_ff;
   logic [23:0]        min_dist_ff;

   // tracking state
   logic               armed_ff;
   logic signed [23:0] last_x_ff, last_y_ff, est_x_ff, est_y_ff;

   // per-item work registers
   logic [15:0]                speed_ff;
   logic                       flip_ff, sel_ff, neg_ff;
   logic signed [CORDIC_W-1:0] s_ff, c_ff;
   logic signed [50:0]         prod_ff;
   logic [DIV_W-1:0]           num_ff;
   logic [DIV_W-1:0]           quo_ff;
   logic [31:0]                xv_ff;
   logic [63:0]                acc_ff;
   logic [15:0]                ang_ff;
   logic [23:0]                dist_ff;

   // finished result and output register
   logic               res_fire_ff, res_armed_ff;
   logic signed [23:0] res_x_ff, res_y_ff;
   logic [23:0]        res_dist_ff;
   logic               rsp_valid_ff;
   logic [79:0]        rsp_data_ff;

   // input beat fields
   logic               in_arm;
   logic signed [23:0] in_fix_x, in_fix_y;
   logic [15:0]        in_speed, in_heading;
   assign in_arm     = req_tdata[0];
   assign in_fix_x   = req_tdata[24:1];
   assign in_fix_y   = req_tdata[48:25];
   assign in_speed   = req_tdata[64:49];
   assign in_heading = req_tdata[80:65];

   // cordic engine hookup
   logic                       cor_load, cor_done;
   cordic_mode_type            cor_mode;
   logic signed [CORDIC_W-1:0] cor_x0, cor_y0, cor_x, cor_y;
   logic signed [ANGLE_W-1:0]  cor_z0, cor_z;

   drrt_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .load   (cor_load),
      .mode   (cor_mode),
      .x_init (cor_x0),
      .y_init (cor_y0),
      .z_init (cor_z0),
      .done   (cor_done),
      .x_out  (cor_x),
      .y_out  (cor_y),
      .z_out  (cor_z)
   );

   // heading fold into +-quarter turn
   logic signed [ANGLE_W-1:0] h_z, rot_z;
   logic                      rot_flip;
   localparam logic signed [ANGLE_W-1:0] QUARTER = 33'sh040000000;
   localparam logic signed [ANGLE_W-1:0] HALF    = 33'sh080000000;
   always_comb begin
      h_z      = signed'({in_heading[15], in_heading, 16'd0});
      rot_z    = h_z;
      rot_flip = 1'b0;
      if (h_z > QUARTER) begin
         rot_z    = h_z - HALF;
         rot_flip = 1'b1;
      end else if (h_z < -QUARTER) begin
         rot_z    = h_z + HALF;
         rot_flip = 1'b1;
      end
   end

   // vector to release point
   logic signed [24:0]         px, py;
   logic signed [CORDIC_W-1:0] vx, vy;
   logic                       vec_zero;
   always_comb begin
      px       = 25'(release_x_ff) - 25'(est_x_ff);
      py       = 25'(release_y_ff) - 25'(est_y_ff);
      vx       = CORDIC_W'(px) <<< 4;
      vy       = CORDIC_W'(py) <<< 4;
      vec_zero = (px == '0) && (py == '0);
   end

   logic start_rot, start_vec;
   assign start_rot = (state_ff == ST_IDLE) && req_tvalid && (in_arm || armed_ff)
                      && (in_fix_x == last_x_ff);
   assign start_vec = (state_ff == ST_VEC_START) && !vec_zero;

   always_comb begin
      cor_load = start_rot || start_vec;
      if (start_vec) begin
         cor_mode = MODE_VECTOR;
         cor_x0   = vx[CORDIC_W-1] ? -vx : vx;
         cor_y0   = vx[CORDIC_W-1] ? -vy : vy;
         cor_z0   = vx[CORDIC_W-1] ? HALF : '0;
      end else begin
         cor_mode = MODE_ROTATE;
         cor_x0   = K_Q30;
         cor_y0   = '0;
         cor_z0   = rot_z;
      end
   end

   // dead reckoning datapath
   logic signed [CORDIC_W-1:0] f_sel;
   logic [50:0]                mag;
   logic [51:0]                rnd;
   logic [54:0]                recip_prod;
   logic signed [25:0]         est_sum;
   logic signed [23:0]         est_cur, est_sat;
   logic signed [22:0]         q_s;
   always_comb begin
      f_sel      = sel_ff ? c_ff : s_ff;
      mag        = prod_ff[50] ? 51'(-prod_ff) : 51'(prod_ff);
      rnd        = 52'(mag) + (52'(TICK_RATE) << 29);
      recip_prod = 55'(num_ff) * 55'(RECIP);
      q_s        = neg_ff ? -signed'({1'b0, quo_ff}) : signed'({1'b0, quo_ff});
      est_cur    = sel_ff ? est_y_ff : est_x_ff;
      est_sum    = 26'(est_cur) + 26'(q_s);
      if (est_sum > 26'sd8388607)
         est_sat = 24'sh7FFFFF;
      else if (est_sum < -26'sd8388608)
         est_sat = 24'sh800000;
      else
         est_sat = est_sum[23:0];
   end

   // release decision
   logic [15:0] rel;
   logic [19:0] r4, tol20, win1_hi, win3_lo, win3_hi;
   logic [33:0] travel;
   logic        near, fire;
   logic [35:0] dist_rnd;
   always_comb begin
      rel      = ang_ff - flight_dir_ff;
      r4       = {2'b0, rel, 2'b0};
      tol20    = 20'(angle_tol_ff);
      win1_hi  = 20'd65536 + tol20;
      win3_lo  = 20'd196608;
      win3_hi  = 20'd196608 + 20'd3 * tol20;
      near     = dist_ff < min_dist_ff;
      travel   = 34'(dist_ff) * 34'(TICK_RATE);
      fire     = (near && r4 < win1_hi && (r4 + tol20) > 20'd65536)
                 || (near && r4 < win3_hi && (r4 + 20'd3 * tol20) > win3_lo)
                 || (travel < 34'(speed_ff));
      dist_rnd = 36'((acc_ff + (64'd1 << 34)) >> 35);
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         armed_ff      <= 1'b0;
         last_x_ff     <= '0;
         last_y_ff     <= '0;
         est_x_ff      <= '0;
         est_y_ff      <= '0;
         release_x_ff  <= '0;
         release_y_ff  <= '0;
         flight_dir_ff <= '0;
         min_dist_ff   <= 24'd2560;
         angle_tol_ff  <= 16'd6554;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_RELEASE_X:  release_x_ff  <= csr_wdata;
               CSR_RELEASE_Y:  release_y_ff  <= csr_wdata;
               CSR_FLIGHT_DIR: flight_dir_ff <= csr_wdata[15:0];
               CSR_MIN_DIST:   min_dist_ff   <= csr_wdata;
               CSR_ANGLE_TOL:  angle_tol_ff  <= csr_wdata[15:0];
               default: ;
            endcase
         end
         // the done step reloads the output register itself
         if (rsp_valid_ff && rsp_tready && state_ff != ST_DONE)
            rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  speed_ff <= in_speed;
                  flip_ff  <= rot_flip;
                  if (!(in_arm || armed_ff)) begin
                     res_fire_ff  <= 1'b0;
                     res_armed_ff <= 1'b0;
                     res_x_ff     <= est_x_ff;
                     res_y_ff     <= est_y_ff;
                     res_dist_ff  <= '0;
                     state_ff     <= ST_DONE;
                  end else begin
                     armed_ff <= 1'b1;
                     if (in_fix_x != last_x_ff) begin
                        est_x_ff  <= in_fix_x;
                        est_y_ff  <= in_fix_y;
                        last_x_ff <= in_fix_x;
                        last_y_ff <= in_fix_y;
                        state_ff  <= ST_VEC_START;
                     end else begin
                        state_ff <= ST_ROT_RUN;
                     end
                  end
               end
            end
            ST_ROT_RUN: begin
               if (cor_done) begin
                  s_ff     <= flip_ff ? -cor_y : cor_y;
                  c_ff     <= flip_ff ? -cor_x : cor_x;
                  sel_ff   <= 1'b0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= signed'({1'b0, speed_ff}) * f_sel;
               state_ff <= ST_DIV_PREP;
            end
            ST_DIV_PREP: begin
               neg_ff   <= prod_ff[50];
               num_ff   <= rnd[51:30];
               state_ff <= ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
               // divide by the tick rate through the reciprocal
               quo_ff   <= recip_prod[53:32];
               state_ff <= ST_ACCUM;
            end
            ST_ACCUM: begin
               if (sel_ff) begin
                  est_y_ff <= est_sat;
                  state_ff <= ST_VEC_START;
               end else begin
                  est_x_ff <= est_sat;
                  sel_ff   <= 1'b1;
                  state_ff <= ST_MUL;
               end
            end
            ST_VEC_START: begin
               if (vec_zero) begin
                  ang_ff   <= '0;
                  dist_ff  <= '0;
                  state_ff <= ST_DECIDE;
               end else begin
                  state_ff <= ST_VEC_RUN;
               end
            end
            ST_VEC_RUN: begin
               if (cor_done) begin
                  xv_ff    <= cor_x[31:0];
                  ang_ff   <= 16'((cor_z[31:0] + 32'h8000) >> 16);
                  state_ff <= ST_DIST_LO;
               end
            end
            ST_DIST_LO: begin
               acc_ff   <= 64'(xv_ff * 48'(K_Q31_LO));
               state_ff <= ST_DIST_HI;
            end
            ST_DIST_HI: begin
               acc_ff   <= acc_ff + (64'(xv_ff * 47'(K_Q31_HI)) << 16);
               state_ff <= ST_DIST_FIN;
            end
            ST_DIST_FIN: begin
               dist_ff  <= (dist_rnd > 36'hFFFFFF) ? 24'hFFFFFF : dist_rnd[23:0];
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               res_fire_ff  <= fire;
               res_armed_ff <= !fire;
               res_x_ff     <= est_x_ff;
               res_y_ff     <= est_y_ff;
               res_dist_ff  <= dist_ff;
               if (fire) begin
                  armed_ff  <= 1'b0;
                  last_x_ff <= '0;
                  last_y_ff <= '0;
                  est_x_ff  <= '0;
                  est_y_ff  <= '0;
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {6'd0, res_dist_ff, res_y_ff, res_x_ff,
                                   res_armed_ff, res_fire_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // a fired tick always reports disarmed
   a_fire_disarms: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("release reported while still armed");

   // a tick seen while disarmed reports zero distance
   a_idle_dist: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0] && !rsp_tdata[1]) |-> (rsp_tdata[73:50] == 24'd0))
      else $error("disarmed tick with nonzero distance");

   // after a release the tracking state is cleared
   a_fire_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && fire) |=> (!armed_ff && est_x_ff == '0 && last_x_ff == '0))
      else $error("tracking state kept after release");

   // the cordic engine is only started from an idle sequencer or the vector step
   a_cordic_start: assert property (@(posedge clock) disable iff (reset)
      cor_load |-> (state_ff == ST_IDLE || state_ff == ST_VEC_START))
      else $error("cordic started mid-sequence");

endmodule

[rtl/core/drrt_cordic.sv]
// shared cordic engine, one micro-rotation per cycle, rotation or vectoring mode
module drrt_cordic #(
   parameter int STEPS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  drrt_pkg::cordic_mode_type             mode,
   input  logic signed [drrt_pkg::CORDIC_W-1:0]  x_init,
   input  logic signed [drrt_pkg::CORDIC_W-1:0]  y_init,
   input  logic signed [drrt_pkg::ANGLE_W-1:0]   z_init,
   output logic                                  done,
   output logic signed [drrt_pkg::CORDIC_W-1:0]  x_out,
   output logic signed [drrt_pkg::CORDIC_W-1:0]  y_out,
   output logic signed [drrt_pkg::ANGLE_W-1:0]   z_out
);
   import drrt_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [ANGLE_W-1:0]  z_ff, z_in;
   logic [4:0]                 i_ff;
   logic                       busy_ff, done_ff;
   cordic_mode_type            mode_ff;
   logic                       dir;
   logic signed [CORDIC_W-1:0] dx, dy;
   logic signed [ANGLE_W-1:0]  a;

   always_comb begin
      dir = (mode_ff == MODE_VECTOR) ? y_ff[CORDIC_W-1] : !z_ff[ANGLE_W-1];
      dx  = y_ff >>> i_ff;
      dy  = x_ff >>> i_ff;
      a   = signed'({1'b0, atan_turn(i_ff)});
      if (dir) begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
         z_in = z_ff - a;
      end else begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
         z_in = z_ff + a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= '0;
         mode_ff <= MODE_ROTATE;
      end else begin
         done_ff <= 1'b0;
         if (load) begin
            busy_ff <= 1'b1;
            i_ff    <= '0;
            mode_ff <= mode;
            x_ff    <= x_init;
            y_ff    <= y_init;
            z_ff    <= z_init;
         end else if (busy_ff) begin
            x_ff <= x_in;
            y_ff <= y_in;
            z_ff <= z_in;
            i_ff <= i_ff + 5'd1;
            if (i_ff == 5'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

[verif/tb.sv]
// testbench for the dead-reckoning release trigger: directed, swept and random ticks
module tb;
   import drrt_pkg::*;

   localparam int TICK_RATE = 60;
   localparam int CORDIC_STEPS = 16;
   localparam int CYCLE_LIMIT = 600000;
   localparam int LONG_HOLD = 400;
   localparam int SETTLE = 150;

   localparam logic [31:0] ATAN_TURN [24] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81};

   typedef struct packed {
      logic [23:0]        distance;
      logic signed [23:0] track_y;
      logic signed [23:0] track_x;
      logic               armed_now;
      logic               release_res;
   } drop_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;
   logic        csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [23:0] csr_wdata;

   dead_reckoning_release_trigger #(
      .TICK_RATE(TICK_RATE),
      .CORDIC_STEPS(CORDIC_STEPS)
   ) dut (.*);

   // predictor state and register copies
   logic               nav_armed;
   logic signed [23:0] nav_last_fx;
   logic signed [23:0] nav_est_x;
   logic signed [23:0] nav_est_y;
   logic signed [23:0] reg_release_x;
   logic signed [23:0] reg_release_y;
   logic [15:0]        reg_flight_dir;
   logic [23:0]        reg_min_dist;
   logic [15:0]        reg_angle_tol;

   drop_result_type pending_drops[$];
   int  mismatch_count;
   int  ticks_sent;
   int  drops_seen;
   int  fires_seen;
   int  cycle_count;
   bit  idle_on;
   bit  hold_long;
   bit  hold_done;
   logic signed [23:0] flight_fx;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic void rotate_heading(input logic [15:0] hdg,
                                          output longint s, output longint c);
      longint z, x, y, dx, dy;
      bit flip;
      z = longint'(hdg) << 16;
      x = 64'sd652032874;
      y = 0;
      flip = 0;
      if (z >= 64'sh80000000) z -= 64'sh100000000;
      if (z > 64'sh40000000) begin
         z -= 64'sh80000000;
         flip = 1;
      end else if (z < -64'sh40000000) begin
         z += 64'sh80000000;
         flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
         end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   function automatic longint tick_travel(input logic [15:0] speed, input longint f);
      longint p, mag, den, q;
      p = longint'(speed) * f;
      mag = (p < 0) ? -p : p;
      den = longint'(TICK_RATE) << 30;
      q = (mag + den / 2) / den;
      return (p < 0) ? -q : q;
   endfunction

   function automatic logic signed [23:0] clamp24(input longint v);
      if (v > 8388607) return 24'sh7FFFFF;
      if (v < -8388608) return -24'sh800000;
      return v[23:0];
   endfunction

   function automatic void range_bearing(input longint px, input longint py,
                                         output logic [15:0] ang,
                                         output logic [23:0] span);
      longint x, y, dx, dy;
      logic [31:0] z, zr;
      logic [63:0] m;
      if (px == 0 && py == 0) begin
         ang = 0;
         span = 0;
         return;
      end
      x = px * 16;
      y = py * 16;
      z = 0;
      if (x < 0) begin
         x = -x; y = -y; z = 32'h80000000;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y < 0) begin
            x -= dx; y += dy; z -= ATAN_TURN[i];
         end else begin
            x += dx; y -= dy; z += ATAN_TURN[i];
         end
      end
      m = (64'(x) * 64'd1304065748 + (64'd1 << 34)) >> 35;
      span = (m > 64'hFFFFFF) ? 24'hFFFFFF : m[23:0];
      zr = z + 32'h8000;
      ang = zr[31:16];
   endfunction

   function automatic drop_result_type predict_tick(input logic arm,
                                                    input logic signed [23:0] fx,
                                                    input logic signed [23:0] fy,
                                                    input logic [15:0] speed,
                                                    input logic [15:0] hdg);
      drop_result_type r;
      longint s, c, r4, tol, md;
      logic [15:0] ang, rel;
      logic [23:0] span;
      bit fire;
      r = '0;
      if (arm) nav_armed = 1;
      if (!nav_armed) begin
         r.track_x = nav_est_x;
         r.track_y = nav_est_y;
         return r;
      end
      if (fx != nav_last_fx) begin
         nav_est_x = fx;
         nav_est_y = fy;
         nav_last_fx = fx;
      end else begin
         rotate_heading(hdg, s, c);
         nav_est_x = clamp24(longint'(nav_est_x) + tick_travel(speed, s));
         nav_est_y = clamp24(longint'(nav_est_y) + tick_travel(speed, c));
      end
      range_bearing(longint'(reg_release_x) - longint'(nav_est_x),
                    longint'(reg_release_y) - longint'(nav_est_y), ang, span);
      rel = ang - reg_flight_dir;
      r4 = longint'(rel) * 4;
      tol = longint'(reg_angle_tol);
      md = longint'(reg_min_dist);
      fire = 0;
      if (span < md && r4 < 65536 + tol && r4 + tol > 65536) fire = 1;
      else if (span < md && r4 < 3 * (65536 + tol) && r4 + 3 * tol > 3 * 65536) fire = 1;
      else if (longint'(span) * TICK_RATE < longint'(speed)) fire = 1;
      r.release_res = fire;
      r.track_x = nav_est_x;
      r.track_y = nav_est_y;
      r.distance = span;
      if (fire) begin
         nav_armed = 0;
         nav_last_fx = 0;
         nav_est_x = 0;
         nav_est_y = 0;
      end
      r.armed_now = nav_armed;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint want);
      mismatch_count++;
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, field, got, want);
   endtask

   // result checker: the beat is taken at the next rising edge
   initial begin
      drop_result_type got, want;
      forever begin
         @(negedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[73:0];
            drops_seen++;
            if (pending_drops.size() == 0) begin
               report_mismatch("unexpected beat", 64'(got), 64'sd0);
            end else begin
               want = pending_drops.pop_front();
               if (got.release_res != want.release_res)
                  report_mismatch("release_res", longint'(got.release_res),
                                  longint'(want.release_res));
               if (got.armed_now != want.armed_now)
                  report_mismatch("armed_now", longint'(got.armed_now),
                                  longint'(want.armed_now));
               if (got.track_x != want.track_x)
                  report_mismatch("track_x", longint'(got.track_x), longint'(want.track_x));
               if (got.track_y != want.track_y)
                  report_mismatch("track_y", longint'(got.track_y), longint'(want.track_y));
               if (got.distance != want.distance)
                  report_mismatch("distance", longint'(got.distance),
                                  longint'(want.distance));
               if (want.release_res) fires_seen++;
            end
         end
      end
   end

   // receiver: random stalls, plus one long hold on request
   initial begin
      rsp_tready = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_long) begin
            rsp_tready <= 0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_long = 0;
            hold_done = 1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            @(posedge clock);
         end
      end
   end

   task automatic send_tick(input logic arm, input logic signed [23:0] fx,
                            input logic signed [23:0] fy, input logic [15:0] speed,
                            input logic [15:0] hdg);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tdata <= {7'd0, hdg, speed, fy, fx, arm};
      req_tvalid <= 1;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      pending_drops.push_back(predict_tick(arm, fx, fy, speed, hdg));
      ticks_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      while (pending_drops.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [23:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
      case (idx)
         CSR_RELEASE_X:  reg_release_x = val;
         CSR_RELEASE_Y:  reg_release_y = val;
         CSR_FLIGHT_DIR: reg_flight_dir = val[15:0];
         CSR_MIN_DIST:   reg_min_dist = val;
         CSR_ANGLE_TOL:  reg_angle_tol = val[15:0];
         default: ;
      endcase
   endtask

   // one approach: arm at a fix near the release point, then mostly dead-reckoned ticks
   task automatic fly_pass(input int n);
      logic signed [23:0] fy;
      logic [15:0] speed;
      flight_fx = reg_release_x + 24'($signed($urandom_range(0, 8000)) - 4000);
      fy = reg_release_y + 24'($signed($urandom_range(0, 8000)) - 4000);
      speed = $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8000));
      send_tick(1, flight_fx, fy, speed, 16'($urandom));
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0: send_tick(1'($urandom), 24'($urandom), 24'($urandom), 16'($urandom),
                         16'($urandom));
            1: begin
               flight_fx = flight_fx + 24'($signed($urandom_range(0, 600)) - 300);
               send_tick(0, flight_fx, fy, speed, 16'($urandom));
            end
            default: send_tick($urandom_range(0, 7) == 0, flight_fx, 24'($urandom),
                               speed, 16'($urandom));
         endcase
      end
   endtask

   task automatic random_registers();
      write_reg(CSR_RELEASE_X, 24'($signed($urandom_range(0, 200000)) - 100000));
      write_reg(CSR_RELEASE_Y, 24'($signed($urandom_range(0, 200000)) - 100000));
      write_reg(CSR_FLIGHT_DIR, 24'($urandom_range(0, 65535)));
      write_reg(CSR_MIN_DIST, 24'($urandom_range(0, 4000)));
      write_reg(CSR_ANGLE_TOL, 24'($urandom_range(0, 65535)));
   endtask

   task automatic test_directed();
      // unarmed ticks report the stored estimate with zero distance
      send_tick(0, 24'sh7FFFFF, -24'sh800000, 16'hFFFF, 16'hFFFF);
      // fix x equal to the stored zero: dead-reckon at zero speed onto the release point
      send_tick(1, 24'sd0, 24'sd0, 16'd0, 16'd0);
      send_tick(0, 24'sd0, 24'sd0, 16'd0, 16'h4000);
      // zero distance with any nonzero speed fires on travel
      send_tick(0, 24'sd0, 24'sd0, 16'd1, 16'h8000);
      // full-speed headings from the largest and the smallest fix, driving saturation
      send_tick(1, 24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF, 16'h0000);
      send_tick(0, 24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF, 16'h0000);
      send_tick(0, 24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF, 16'h4000);
      send_tick(0, 24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF, 16'h8000);
      send_tick(0, 24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF, 16'hC000);
      send_tick(0, 24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF, 16'hFFFF);
      send_tick(1, -24'sh800000, -24'sh800000, 16'hFFFF, 16'h2000);
      send_tick(0, -24'sh800000, -24'sh800000, 16'hFFFF, 16'hA000);
      send_tick(0, -24'sh800000, -24'sh800000, 16'hFFFF, 16'hA000);
      // new fixes near the release point, some in the quarter and three-quarter windows
      send_tick(1, 24'sd0, 24'sd512, 16'd0, 16'd0);
      send_tick(1, 24'sd0, -24'sd512, 16'd0, 16'd0);
      send_tick(1, 24'sd300, 24'sd0, 16'd0, 16'd0);
      send_tick(1, -24'sd300, 24'sd0, 16'd0, 16'd0);
      send_tick(1, 24'sd5, 24'sd1, 16'd400, 16'h1234);
      wait_drained();
   endtask

   task automatic test_register_extremes();
      write_reg(CSR_RELEASE_X, 24'h7FFFFF);
      write_reg(CSR_RELEASE_Y, 24'h800000);
      write_reg(CSR_FLIGHT_DIR, 24'h00FFFF);
      write_reg(CSR_MIN_DIST, 24'hFFFFFF);
      write_reg(CSR_ANGLE_TOL, 24'h00FFFF);
      send_tick(1, -24'sh800000, 24'sh7FFFFF, 16'd100, 16'd0);
      send_tick(0, -24'sh800000, 24'sh7FFFFF, 16'd100, 16'd0);
      fly_pass(10);
      wait_drained();
      write_reg(CSR_RELEASE_X, 24'h800000);
      write_reg(CSR_RELEASE_Y, 24'h7FFFFF);
      write_reg(CSR_FLIGHT_DIR, 24'h000000);
      write_reg(CSR_MIN_DIST, 24'h000000);
      write_reg(CSR_ANGLE_TOL, 24'h000000);
      fly_pass(10);
      wait_drained();
   endtask

   task automatic test_setting_sweep();
      for (int k = 0; k < 12; k++) begin
         random_registers();
         for (int j = 0; j < 3; j++) fly_pass($urandom_range(5, 15));
         wait_drained();
      end
   endtask

   task automatic test_output_stall();
      hold_done = 0;
      hold_long = 1;
      fly_pass(12);
      while (!hold_done) @(posedge clock);
      wait_drained();
   endtask

   task automatic test_steady_stream();
      random_registers();
      idle_on = 0;
      for (int j = 0; j < 6; j++) fly_pass($urandom_range(8, 16));
      wait_drained();
   endtask

   initial begin
      clock = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      mismatch_count = 0;
      ticks_sent = 0;
      drops_seen = 0;
      fires_seen = 0;
      idle_on = 1;
      hold_long = 0;
      hold_done = 0;
      nav_armed = 0;
      nav_last_fx = 0;
      nav_est_x = 0;
      nav_est_y = 0;
      reg_release_x = 0;
      reg_release_y = 0;
      reg_flight_dir = 0;
      reg_min_dist = 24'd2560;
      reg_angle_tol = 16'd6554;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      test_directed();
      test_register_extremes();
      test_output_stall();
      test_setting_sweep();
      test_steady_stream();

      $display("covered %0d ticks, %0d result beats, %0d releases fired", ticks_sent,
               drops_seen, fires_seen);
      $display("register extremes, long output stall, drained pauses and a gapless stream");
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/drrt_pkg.sv
rtl/core/drrt_cordic.sv
rtl/core/dead_reckoning_release_trigger.sv
verif/tb.sv
